>>> design/pic_pkg.sv
// Package for the priority interrupt controller: item and result types,
// access codes, init phases and the priority encoder. No dependencies.
`timescale 1ns / 1ps

package pic_pkg;

    // Access kind carried in tuser
    typedef enum logic [2:0] {
        FUNC_WR_CMD  = 3'd0,
        FUNC_WR_DATA = 3'd1,
        FUNC_RD_CMD  = 3'd2,
        FUNC_RD_DATA = 3'd3,
        FUNC_SAMPLE  = 3'd4,
        FUNC_ACK     = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        PH_OPER = 2'd0,
        PH_ICW2 = 2'd1,
        PH_ICW3 = 2'd2,
        PH_ICW4 = 2'd3
    } phase_t;

    // Command word decode
    localparam int ICW1_BIT = 4;
    localparam int OCW3_BIT = 3;
    localparam int OCW3_RR_BIT = 1;
    localparam int OCW3_RIS_BIT = 0;
    localparam int ICW1_IC4_BIT = 0;
    localparam int ICW1_SNGL_BIT = 1;
    localparam logic [2:0] OCW2_EOI_NONSPEC = 3'b001;
    localparam logic [2:0] OCW2_EOI_SPEC = 3'b011;
    localparam logic [2:0] SPURIOUS_LINE = 3'd7;

    typedef struct packed {
        func_t       func;
        logic [7:0]  wdata;
        logic [7:0]  irq_lines;
    } item_t;

    // Packed so that rdata sits in the low bits
    typedef struct packed {
        logic        vector_valid;
        logic [7:0]  vector;
        logic        int_request;
        logic [7:0]  rdata;
    } result_t;

    // Lowest set bit number; bit 3 of the result set means none
    function automatic logic [3:0] lowest_line(input logic [7:0] bits);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (bits[i]) begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

endpackage

>>> design/pic_core.sv
// Controller state and the single-pass update for one item.
// Depends on pic_pkg.
`timescale 1ns / 1ps

module pic_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  pic_pkg::item_t   item,
    output pic_pkg::result_t result
);
    import pic_pkg::*;

    phase_t     phase_reg, phase_next;
    logic       ic4_reg, ic4_next;
    logic       single_reg, single_next;
    logic [4:0] base_reg, base_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] irr_reg, irr_next;
    logic [7:0] isr_reg, isr_next;
    logic       ris_reg, ris_next;
    logic [7:0] prev_reg, prev_next;

    logic [3:0] req_line, svc_line, grant_line;
    logic [3:0] req_line_next, svc_line_next;

    always_comb begin
        req_line   = lowest_line(irr_reg & ~mask_reg);
        svc_line   = lowest_line(isr_reg);
        grant_line = (req_line < svc_line) ? req_line : 4'd8;

        phase_next  = phase_reg;
        ic4_next    = ic4_reg;
        single_next = single_reg;
        base_next   = base_reg;
        mask_next   = mask_reg;
        irr_next    = irr_reg;
        isr_next    = isr_reg;
        ris_next    = ris_reg;
        prev_next   = prev_reg;
        result      = '0;

        unique case (item.func)
            FUNC_WR_CMD: begin
                if (item.wdata[ICW1_BIT]) begin
                    ic4_next    = item.wdata[ICW1_IC4_BIT];
                    single_next = item.wdata[ICW1_SNGL_BIT];
                    phase_next  = PH_ICW2;
                    mask_next   = '0;
                    irr_next    = '0;
                    isr_next    = '0;
                    ris_next    = 1'b0;
                end else if (item.wdata[OCW3_BIT]) begin
                    if (item.wdata[OCW3_RR_BIT]) begin
                        ris_next = item.wdata[OCW3_RIS_BIT];
                    end
                end else begin
                    if (item.wdata[7:5] == OCW2_EOI_NONSPEC) begin
                        if (!svc_line[3]) begin
                            isr_next = isr_reg & ~(8'd1 << svc_line[2:0]);
                        end
                    end else if (item.wdata[7:5] == OCW2_EOI_SPEC) begin
                        isr_next = isr_reg & ~(8'd1 << item.wdata[2:0]);
                    end
                end
            end
            FUNC_WR_DATA: begin
                // ICW3 and ICW4 contents do not affect this controller
                unique case (phase_reg)
                    PH_ICW2: begin
                        base_next = item.wdata[7:3];
                        if (!single_reg) begin
                            phase_next = PH_ICW3;
                        end else begin
                            phase_next = ic4_reg ? PH_ICW4 : PH_OPER;
                        end
                    end
                    PH_ICW3: phase_next = ic4_reg ? PH_ICW4 : PH_OPER;
                    PH_ICW4: phase_next = PH_OPER;
                    default: mask_next = item.wdata;
                endcase
            end
            FUNC_RD_CMD: result.rdata = ris_reg ? isr_reg : irr_reg;
            FUNC_RD_DATA: result.rdata = mask_reg;
            FUNC_SAMPLE: begin
                irr_next  = irr_reg | (item.irq_lines & ~prev_reg);
                prev_next = item.irq_lines;
            end
            FUNC_ACK: begin
                if (!grant_line[3]) begin
                    irr_next            = irr_reg & ~(8'd1 << grant_line[2:0]);
                    isr_next            = isr_reg | (8'd1 << grant_line[2:0]);
                    result.vector       = {base_reg, grant_line[2:0]};
                    result.vector_valid = 1'b1;
                end else begin
                    result.vector = {base_reg, SPURIOUS_LINE};
                end
            end
            default: ;
        endcase

        // interrupt output reflects the state after this item
        req_line_next      = lowest_line(irr_next & ~mask_next);
        svc_line_next      = lowest_line(isr_next);
        result.int_request = (req_line_next < svc_line_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_OPER;
            ic4_reg    <= 1'b0;
            single_reg <= 1'b0;
            base_reg   <= '0;
            mask_reg   <= '0;
            irr_reg    <= '0;
            isr_reg    <= '0;
            ris_reg    <= 1'b0;
            prev_reg   <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            ic4_reg    <= ic4_next;
            single_reg <= single_next;
            base_reg   <= base_next;
            mask_reg   <= mask_next;
            irr_reg    <= irr_next;
            isr_reg    <= isr_next;
            ris_reg    <= ris_next;
            prev_reg   <= prev_next;
        end
    end

endmodule

>>> design/priority_interrupt_controller.sv
// Priority interrupt controller: one eight-input controller with fixed priority
// (line 0 highest) and edge-triggered requests. Each input item is a command or
// data port write, a command or data port read, a sample of the request lines or
// an acknowledge, selected by s_axis_tuser; every item yields exactly one result
// item. Throughput is one item per clock while results are taken without stalls; an
// item's result passes through the input register, then the result register, with
// the priority encoders and state update in between, and is presented on the
// result side from the result register. The input side keeps accepting while a
// result waits for m_axis_tready, until both registers are full.
// Depends on pic_pkg and pic_core.
`timescale 1ns / 1ps

module priority_interrupt_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // wdata[7:0], irq_lines[15:8]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // rdata[7:0], int_request[8], vector[16:9],
                                        // vector_valid[17], zero[23:18]
);
    import pic_pkg::*;

    logic    in_valid_reg;
    item_t   in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t core_result;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_reg.func      <= func_t'(s_axis_tuser);
            in_reg.wdata     <= s_axis_tdata[7:0];
            in_reg.irq_lines <= s_axis_tdata[15:8];
        end
    end

    pic_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg};

    // acknowledge results never carry read data
    a_ack_no_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.vector_valid) |-> (out_reg.rdata == 8'd0))
        else $error("acknowledge result carries read data");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a held item is not dropped
    a_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled item lost from input register");

endmodule
